### rtl/ldprf_pkg.sv
// Shared types and constants for the L4 destination port range filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ldprf_pkg;

  // Configuration register indexes
  localparam logic [0:0] REG_PORT_RANGE_BASE  = 1'b0;
  localparam logic [0:0] REG_PORT_RANGE_COUNT = 1'b1;

  // Configuration reset values
  localparam logic [15:0] PORT_RANGE_BASE_RST  = 16'd10000;
  localparam logic [15:0] PORT_RANGE_COUNT_RST = 16'd128;

  // Byte positions inside the frame
  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL      = 7'd14;
  localparam logic [6:0] POS_PROTO    = 7'd23;
  localparam logic [6:0] POS_L4_BASE  = 7'd14;
  localparam logic [6:0] PORT_OFS     = 7'd2;
  localparam logic [6:0] POS_MAX      = 7'd127;

  // Length thresholds, in bytes of frame
  localparam logic [7:0] ETH_HDR_LEN      = 8'd14;
  localparam logic [7:0] MIN_IP_FRAME_LEN = 8'd34;
  localparam logic [7:0] TCP_HDR_LEN      = 8'd20;
  localparam logic [7:0] UDP_HDR_LEN      = 8'd8;
  localparam logic [3:0] MIN_IHL          = 4'd5;

  // Header codes
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Classified frame handed from the parser to the range check
  typedef struct packed {
    logic        eligible;  // IPv4 TCP/UDP with complete headers
    logic [15:0] port;      // captured destination port
  } verdict_req_t;

endpackage

`default_nettype wire

### rtl/ldprf_front.sv
// Front end: byte parser that captures header fields and classifies a frame
// on its last byte. Depends on ldprf_pkg.
`default_nettype none

module ldprf_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            frame_byte,
  input  wire logic                  frame_last,
  output logic                       push,
  output ldprf_pkg::verdict_req_t    push_req,
  input  wire logic                  queue_ready
);
  import ldprf_pkg::*;

  logic [6:0]  byte_position;
  logic [15:0] ether_kind;
  logic [3:0]  header_words;
  logic [7:0]  ip_proto;
  logic [15:0] dest_port;

  logic        accept;
  logic [7:0]  frame_len;
  logic [6:0]  port_at;
  logic [7:0]  l4_start;
  logic [7:0]  need;
  logic        l4_known;
  logic        eligible;

  assign in_ready = queue_ready;
  assign accept   = in_valid && in_ready;

  // Port position and header length derived from the captured IHL
  assign port_at   = POS_L4_BASE + {1'b0, header_words, 2'b00} + PORT_OFS;
  assign frame_len = {1'b0, byte_position} + 8'd1;
  assign l4_start  = ETH_HDR_LEN + {2'b00, header_words, 2'b00};

  // L4 header size by protocol
  always_comb begin
    need     = UDP_HDR_LEN;
    l4_known = 1'b0;
    if (ip_proto == PROTO_TCP) begin
      need     = TCP_HDR_LEN;
      l4_known = 1'b1;
    end else if (ip_proto == PROTO_UDP) begin
      need     = UDP_HDR_LEN;
      l4_known = 1'b1;
    end
  end

  // Header checks; fields captured on this byte are never needed here
  assign eligible = (ether_kind == ETHERTYPE_IPV4) &&
                    (frame_len >= MIN_IP_FRAME_LEN) &&
                    (header_words >= MIN_IHL) &&
                    (l4_start <= frame_len) &&
                    l4_known &&
                    (frame_len >= l4_start + need);

  assign push              = accept && frame_last;
  assign push_req.eligible = eligible;
  assign push_req.port     = dest_port;

  // Field capture and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ether_kind    <= '0;
      header_words  <= '0;
      ip_proto      <= '0;
      dest_port     <= '0;
    end else if (accept) begin
      if (frame_last) begin
        byte_position <= '0;
        ether_kind    <= '0;
        header_words  <= '0;
        ip_proto      <= '0;
        dest_port     <= '0;
      end else begin
        if (byte_position == POS_ETYPE_HI) begin
          ether_kind[15:8] <= frame_byte;
        end else if (byte_position == POS_ETYPE_LO) begin
          ether_kind[7:0] <= frame_byte;
        end else if (byte_position == POS_IHL) begin
          header_words <= frame_byte[3:0];
        end else if (byte_position == POS_PROTO) begin
          ip_proto <= frame_byte;
        end
        if (byte_position > POS_IHL && byte_position < POS_MAX) begin
          if (byte_position == port_at) begin
            dest_port[15:8] <= frame_byte;
          end else if (byte_position == port_at + 7'd1) begin
            dest_port[7:0] <= frame_byte;
          end
        end
        if (byte_position < POS_MAX) begin
          byte_position <= byte_position + 7'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ldprf_queue.sv
// Small FIFO that decouples the parser from the range check.
// Depends on ldprf_pkg for the entry type.
`default_nettype none

module ldprf_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  ldprf_pkg::verdict_req_t    wr_data,
  output logic                       wr_ready,
  output logic                       rd_valid,
  output ldprf_pkg::verdict_req_t    rd_data,
  input  wire logic                  rd_en
);
  import ldprf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  verdict_req_t    entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (fill != FULL_CNT);
  assign rd_valid = (fill != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ldprf_back.sv
// Back end: port range registers, range compare and the output register.
// Depends on ldprf_pkg.
`default_nettype none

module ldprf_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire logic                  req_valid,
  input  ldprf_pkg::verdict_req_t    req,
  output logic                       req_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       drop
);
  import ldprf_pkg::*;

  logic [15:0] port_range_base;
  logic [15:0] port_range_count;
  logic [16:0] range_end;
  logic        in_range;
  logic        drop_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      port_range_base  <= PORT_RANGE_BASE_RST;
      port_range_count <= PORT_RANGE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PORT_RANGE_BASE:  port_range_base  <= cfg_data;
        REG_PORT_RANGE_COUNT: port_range_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Range compare, end formed in 17 bits so it never wraps
  assign range_end = {1'b0, port_range_base} + {1'b0, port_range_count};
  assign in_range  = (req.port >= port_range_base) && ({1'b0, req.port} < range_end);
  assign drop_next = req.eligible && in_range;

  // Output register takes a new verdict when empty or being drained
  assign req_pop = req_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      drop <= drop_next;
    end
  end

endmodule

`default_nettype wire

### rtl/l4_dest_port_range_filter_core.sv
// L4 destination port range filter: top level joining parser, queue and
// range check. Depends on ldprf_pkg, ldprf_front, ldprf_queue, ldprf_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one Ethernet frame byte per request,
//   starting at the destination MAC, frame_last set on the final byte.
//   Output channel (out_valid/out_ready): one drop verdict per frame.
//   Config port: cfg_we writes cfg_data[15:0] to register cfg_index
//   (0 = port_range_base, 1 = port_range_count); write only while idle.
// Throughput: one byte per cycle; the parser never stalls while the verdict
//   queue has room, and a verdict per cycle can drain when out_ready is high.
// Path: with the output free, the verdict is written into the queue as the last
//   byte is accepted, then loaded into the output register, raising out_valid.
// Stall: when out_ready is low, up to QUEUE_DEPTH verdicts wait in the queue
//   plus one in the output register; in_ready drops only when the queue fills.
// Reset: rst (synchronous) clears the parser, empties the queue and loads
//   base 10000 and count 128.
`default_nettype none

module l4_dest_port_range_filter_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             drop,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import ldprf_pkg::*;

  logic         push;
  verdict_req_t push_req;
  logic         queue_ready;
  logic         req_valid;
  verdict_req_t req;
  logic         req_pop;

  // Parser
  ldprf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last),
    .push        (push),
    .push_req    (push_req),
    .queue_ready (queue_ready)
  );

  // Verdict queue
  ldprf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (push_req),
    .wr_ready (queue_ready),
    .rd_valid (req_valid),
    .rd_data  (req),
    .rd_en    (req_pop)
  );

  // Range check and output
  ldprf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drop      (drop)
  );

endmodule

`default_nettype wire
